>>> rtl/core/swmrt_pkg.sv
`default_nettype none

package swmrt_pkg;

  // pool size default
  localparam int unsigned DefaultPages = 32;

  // page geometry
  localparam int unsigned IdxBits   = 10;
  localparam int unsigned PageWords = 1024;
  localparam int unsigned Levels    = 3;

  // returned when a set runs out of pages
  localparam logic [31:0] FailWord = 32'hFFFF_FFFF;

  // command codes
  localparam logic [1:0] CMD_GET   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [31:0] value;
  } in_t;

  // result beat
  typedef struct packed {
    logic [31:0] result_value;
    logic        out_of_pages;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/core/swmrt_stream_if.sv
`default_nettype none

interface swmrt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/swmrt_ram.sv
`default_nettype none

module swmrt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/sparse_word_map_radix_table.sv
// Sparse word map kept as a three-level radix table of 1024-word pages.
// Input channel in_i carries command, address and value; output channel
// out_o carries result_value and out_of_pages, one result beat per input
// beat, in order. Commands: get, set, clear (code 3 is a no-op).
// One item is worked at a time. A get or a set whose path exists walks the
// three levels, each costing a read step plus a data step on the single-port
// page memory; then the leaf is returned (and written on a set).
// Each page allocated by a set adds the walk step that finds the slot empty,
// a zero-fill sweep over the new page, one word per cycle, then a link step.
// Clear and code 3 go straight to the result. The next item can be accepted
// in the cycle after its predecessor's result is registered.
// The result sits in an output register; the next item is accepted while
// it waits, and a finished result waits for the register to drain when the
// receiver stalls.
// Reset empties the map (no root, full pool) and needs no sweep: page
// contents are zero-filled on allocation.
`default_nettype none

module sparse_word_map_radix_table #(
  parameter int unsigned PAGES = swmrt_pkg::DefaultPages
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  swmrt_stream_if.sink   in_i,
  swmrt_stream_if.source out_o
);

  localparam int unsigned PW    = $clog2(PAGES);
  localparam int unsigned AW    = PW + swmrt_pkg::IdxBits;
  localparam int unsigned LW    = $clog2(PAGES + 1);
  localparam int unsigned DEPTH = PAGES * swmrt_pkg::PageWords;
  localparam int unsigned IW    = swmrt_pkg::IdxBits;

  // state codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [1:0]             cmd_q, cmd_d;
  logic [3*IW-1:0]        widx_q, widx_d;
  logic [31:0]            value_q, value_d;
  logic [31:0]            link_q, link_d;
  logic [AW-1:0]          slot_q, slot_d;
  logic [1:0]             lvl_q, lvl_d;
  logic [PW-1:0]          clr_page_q, clr_page_d;
  logic [IW-1:0]          clr_cnt_q, clr_cnt_d;
  logic [LW-1:0]          root_q, root_d;
  logic [LW-1:0]          free_q, free_d;
  swmrt_pkg::out_t        res_q, res_d;
  swmrt_pkg::out_t        out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [31:0]            mem_wdata;
  logic [31:0]            mem_rdata;

  logic                   in_fire;
  logic                   link_ok;
  logic [IW-1:0]          idx_sel;
  logic [PW-1:0]          link_page;
  logic [AW-1:0]          rd_addr;
  logic [31:0]            new_link;

  swmrt_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // walk helpers
  assign link_ok   = (link_q != 32'd0) && (link_q <= 32'(PAGES));
  assign link_page = PW'(link_q - 32'd1);
  assign rd_addr   = {link_page, idx_sel};
  assign new_link  = 32'(clr_page_q) + 32'd1;

  always_comb begin
    unique case (lvl_q)
      2'd0:    idx_sel = widx_q[3*IW-1:2*IW];
      2'd1:    idx_sel = widx_q[2*IW-1:IW];
      default: idx_sel = widx_q[IW-1:0];
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    widx_d      = widx_q;
    value_d     = value_q;
    link_d      = link_q;
    slot_d      = slot_q;
    lvl_d       = lvl_q;
    clr_page_d  = clr_page_q;
    clr_cnt_d   = clr_cnt_q;
    root_d      = root_q;
    free_d      = free_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_addr    = rd_addr;
    mem_wdata   = 32'd0;

    // output register drains independently
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d   = in_i.payload.command;
          widx_d  = in_i.payload.address[31:2];
          value_d = in_i.payload.value;
          link_d  = 32'(root_q);
          lvl_d   = 2'd0;
          res_d   = '0;
          if (in_i.payload.command == swmrt_pkg::CMD_GET ||
              in_i.payload.command == swmrt_pkg::CMD_SET) begin
            state_d = S_WALK;
          end else begin
            if (in_i.payload.command == swmrt_pkg::CMD_CLEAR) begin
              root_d = '0;
              free_d = LW'(PAGES);
            end
            state_d = S_RESP;
          end
        end
      end

      S_WALK: begin
        if (lvl_q == 2'd3) begin
          // leaf reached: link_q holds the old word
          if (cmd_q == swmrt_pkg::CMD_SET) begin
            mem_we    = 1'b1;
            mem_addr  = slot_q;
            mem_wdata = value_q;
          end
          res_d   = '{result_value: link_q, out_of_pages: 1'b0};
          state_d = S_RESP;
        end else if (link_ok) begin
          slot_d  = rd_addr;
          state_d = S_READ;
        end else if (cmd_q == swmrt_pkg::CMD_GET || value_q == 32'd0) begin
          res_d   = '0;
          state_d = S_RESP;
        end else if (free_q == '0) begin
          res_d   = '{result_value: swmrt_pkg::FailWord, out_of_pages: 1'b1};
          state_d = S_RESP;
        end else begin
          free_d     = free_q - LW'(1);
          clr_page_d = PW'(free_q - LW'(1));
          clr_cnt_d  = '0;
          state_d    = S_CLEAR;
        end
      end

      S_READ: begin
        link_d  = mem_rdata;
        lvl_d   = lvl_q + 2'd1;
        state_d = S_WALK;
      end

      S_CLEAR: begin
        // zero-fill the new page
        mem_we    = 1'b1;
        mem_addr  = {clr_page_q, clr_cnt_q};
        mem_wdata = 32'd0;
        clr_cnt_d = clr_cnt_q + IW'(1);
        if (clr_cnt_q == {IW{1'b1}}) begin
          state_d = S_LINK;
        end
      end

      S_LINK: begin
        // hook the new page into its parent slot
        if (lvl_q == 2'd0) begin
          root_d = LW'(clr_page_q) + LW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_addr  = slot_q;
          mem_wdata = new_link;
        end
        link_d  = new_link;
        state_d = S_WALK;
      end

      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      root_q      <= '0;
      free_q      <= LW'(PAGES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_q      <= root_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    widx_q     <= widx_d;
    value_q    <= value_d;
    link_q     <= link_d;
    slot_q     <= slot_d;
    lvl_q      <= lvl_d;
    clr_page_q <= clr_page_d;
    clr_cnt_q  <= clr_cnt_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

`default_nettype wire
